// ----- sv/pm25aqi_pkg.sv -----
// Shared types and constants for the PM2.5 to air quality index pipeline.
// Band tables, reciprocal constants and category codes; no dependencies.
package pm25aqi_pkg;

    localparam int PM_W    = 14;
    localparam int RH_W    = 10;
    localparam int CONC_W  = 28;   // signed corrected concentration, 1e-5 ug/m3
    localparam int DIST_W  = 27;   // offset from band lower breakpoint
    localparam int NUM_W   = 34;   // 2*span*delta + den
    localparam int RCP_W   = 13;
    localparam int QUO_W   = 10;
    localparam int AQI_W   = 10;
    localparam int CAT_W   = 3;
    localparam int BAND_W  = 3;
    localparam int NUM_BANDS   = 7;
    localparam int RECIP_SHIFT = 34;

    localparam logic [12:0] PM_GAIN  = 13'd5340;
    localparam logic [9:0]  RH_GAIN  = 10'd844;
    localparam logic [19:0] OFFSET   = 20'd560400;

    // Band 0 is the top band, band 6 the good band.
    localparam logic [DIST_W-1:0] BAND_LO [NUM_BANDS] = '{
        27'd35050000, 27'd25050000, 27'd15050000, 27'd5550000,
        27'd3550000,  27'd1210000,  27'd0
    };
    // Band width in concentration (den) and twice that (divisor).
    localparam logic [23:0] BAND_HALF [NUM_BANDS] = '{
        24'd14990000, 24'd9990000, 24'd9990000, 24'd9490000,
        24'd1990000,  24'd2330000, 24'd1200000
    };
    localparam logic [24:0] BAND_DIV [NUM_BANDS] = '{
        25'd29980000, 25'd19980000, 25'd19980000, 25'd18980000,
        25'd3980000,  25'd4660000,  25'd2400000
    };
    localparam logic [6:0] BAND_SPAN [NUM_BANDS] = '{
        7'd99, 7'd99, 7'd99, 7'd49, 7'd49, 7'd49, 7'd50
    };
    localparam logic [8:0] BAND_IDX_LO [NUM_BANDS] = '{
        9'd401, 9'd301, 9'd201, 9'd151, 9'd101, 9'd51, 9'd0
    };
    // floor(2^RECIP_SHIFT / divisor)
    localparam logic [RCP_W-1:0] BAND_RECIP [NUM_BANDS] = '{
        RCP_W'((64'd1 << RECIP_SHIFT) / 64'd29980000),
        RCP_W'((64'd1 << RECIP_SHIFT) / 64'd19980000),
        RCP_W'((64'd1 << RECIP_SHIFT) / 64'd19980000),
        RCP_W'((64'd1 << RECIP_SHIFT) / 64'd18980000),
        RCP_W'((64'd1 << RECIP_SHIFT) / 64'd3980000),
        RCP_W'((64'd1 << RECIP_SHIFT) / 64'd4660000),
        RCP_W'((64'd1 << RECIP_SHIFT) / 64'd2400000)
    };

    localparam logic [BAND_W-1:0] BAND_GOOD = 3'd6;

    localparam logic [CAT_W-1:0] CAT_GOOD       = 3'd0;
    localparam logic [CAT_W-1:0] CAT_MODERATE   = 3'd1;
    localparam logic [CAT_W-1:0] CAT_SENSITIVE  = 3'd2;
    localparam logic [CAT_W-1:0] CAT_UNHEALTHY  = 3'd3;
    localparam logic [CAT_W-1:0] CAT_VERY_UNHLT = 3'd4;
    localparam logic [CAT_W-1:0] CAT_HAZARDOUS  = 3'd5;

    typedef struct packed {
        logic              neg;
        logic [BAND_W-1:0] band;
        logic [DIST_W-1:0] delta;
    } band_t;

    typedef struct packed {
        logic              neg;
        logic [BAND_W-1:0] band;
        logic [QUO_W-1:0]  quo;
    } quo_t;

endpackage

// ----- sv/pm25aqi_corr.sv -----
// Humidity correction and band select: two pipeline stages.
// Depends on pm25aqi_pkg.
module pm25aqi_corr (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pm25aqi_pkg::PM_W-1:0] pm25_tenths,
    input  logic [pm25aqi_pkg::RH_W-1:0] humidity_tenths,
    output logic                         out_valid,
    input  logic                         out_ready,
    output pm25aqi_pkg::band_t           out_band
);
    import pm25aqi_pkg::*;

    logic              a_vld_reg;
    logic              b_vld_reg;
    logic              a_rdy;
    logic              b_rdy;
    logic [CONC_W-1:0] corr_reg;
    logic [CONC_W-1:0] corr_next;
    logic [26:0]       pm_term;
    logic [19:0]       rh_term;
    band_t             band_reg;
    band_t             band_next;
    logic [BAND_W-1:0] sel;
    logic [DIST_W-1:0] mag;

    assign b_rdy    = !b_vld_reg || out_ready;
    assign a_rdy    = !a_vld_reg || b_rdy;
    assign in_ready = a_rdy;

    // stage A: C = 5340*pm - 844*rh + 560400
    always_comb
    begin
        pm_term   = 27'(PM_GAIN) * 27'(pm25_tenths);
        rh_term   = 20'(RH_GAIN) * 20'(humidity_tenths);
        corr_next = 28'(pm_term) + 28'(OFFSET) - 28'(rh_term);
    end

    // stage B: strict-greater breakpoint search, top band wins
    always_comb
    begin
        mag = corr_reg[DIST_W-1:0];
        sel = BAND_GOOD;
        for (int i = NUM_BANDS - 2; i >= 0; i--)
        begin
            if (mag > BAND_LO[i])
            begin
                sel = BAND_W'(i);
            end
        end
        band_next.neg   = corr_reg[CONC_W-1];
        band_next.band  = sel;
        band_next.delta = mag - BAND_LO[sel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
            begin
                a_vld_reg <= in_valid;
            end
            if (b_rdy)
            begin
                b_vld_reg <= a_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_rdy)
        begin
            corr_reg <= corr_next;
        end
        if (a_vld_reg && b_rdy)
        begin
            band_reg <= band_next;
        end
    end

    assign out_valid = b_vld_reg;
    assign out_band  = band_reg;

endmodule

// ----- sv/pm25aqi_interp.sv -----
// Interpolation within the band: numerator, reciprocal multiply, correction.
// Three pipeline stages; depends on pm25aqi_pkg.
module pm25aqi_interp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pm25aqi_pkg::band_t in_band,
    output logic               out_valid,
    input  logic               out_ready,
    output pm25aqi_pkg::quo_t  out_quo
);
    import pm25aqi_pkg::*;

    logic                       c_vld_reg;
    logic                       d_vld_reg;
    logic                       e_vld_reg;
    logic                       c_rdy;
    logic                       d_rdy;
    logic                       e_rdy;
    logic [NUM_W-2:0]           span_prod;
    logic [NUM_W-1:0]           num_next;
    logic [NUM_W-1:0]           num_c_reg;
    logic [NUM_W-1:0]           num_d_reg;
    logic                       neg_c_reg;
    logic                       neg_d_reg;
    logic [BAND_W-1:0]          band_c_reg;
    logic [BAND_W-1:0]          band_d_reg;
    logic [NUM_W+RCP_W-1:0]     rcp_prod;
    logic [QUO_W-1:0]           q0_next;
    logic [QUO_W-1:0]           q0_reg;
    logic [NUM_W-1:0]           back_prod;
    logic [NUM_W-1:0]           rem;
    quo_t                       quo_next;
    quo_t                       quo_reg;

    assign e_rdy    = !e_vld_reg || out_ready;
    assign d_rdy    = !d_vld_reg || e_rdy;
    assign c_rdy    = !c_vld_reg || d_rdy;
    assign in_ready = c_rdy;

    // stage C: n = 2*span*delta + den
    always_comb
    begin
        span_prod = (NUM_W-1)'(BAND_SPAN[in_band.band]) * (NUM_W-1)'(in_band.delta);
        num_next  = {span_prod, 1'b0} + NUM_W'(BAND_HALF[in_band.band]);
    end

    // stage D: q0 = floor(n * recip / 2^shift), at most one below the true quotient
    always_comb
    begin
        rcp_prod = (NUM_W+RCP_W)'(num_c_reg) * (NUM_W+RCP_W)'(BAND_RECIP[band_c_reg]);
        q0_next  = rcp_prod[RECIP_SHIFT +: QUO_W];
    end

    // stage E: bump q0 when the remainder still holds a full divisor
    always_comb
    begin
        back_prod     = NUM_W'(q0_reg) * NUM_W'(BAND_DIV[band_d_reg]);
        rem           = num_d_reg - back_prod;
        quo_next.neg  = neg_d_reg;
        quo_next.band = band_d_reg;
        quo_next.quo  = q0_reg + QUO_W'(rem >= NUM_W'(BAND_DIV[band_d_reg]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else
        begin
            if (c_rdy)
            begin
                c_vld_reg <= in_valid;
            end
            if (d_rdy)
            begin
                d_vld_reg <= c_vld_reg;
            end
            if (e_rdy)
            begin
                e_vld_reg <= d_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && c_rdy)
        begin
            num_c_reg  <= num_next;
            neg_c_reg  <= in_band.neg;
            band_c_reg <= in_band.band;
        end
        if (c_vld_reg && d_rdy)
        begin
            q0_reg     <= q0_next;
            num_d_reg  <= num_c_reg;
            neg_d_reg  <= neg_c_reg;
            band_d_reg <= band_c_reg;
        end
        if (d_vld_reg && e_rdy)
        begin
            quo_reg <= quo_next;
        end
    end

    assign out_valid = e_vld_reg;
    assign out_quo   = quo_reg;

endmodule

// ----- sv/pm25aqi_grade.sv -----
// Final stage: band offset, saturation, category code, output register.
// Depends on pm25aqi_pkg.
module pm25aqi_grade (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pm25aqi_pkg::quo_t             in_quo,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pm25aqi_pkg::AQI_W-1:0] aqi_value,
    output logic [pm25aqi_pkg::CAT_W-1:0] category_code,
    output logic                          result_valid
);
    import pm25aqi_pkg::*;

    logic             o_vld_reg;
    logic             o_rdy;
    logic [AQI_W:0]   sum;
    logic [AQI_W-1:0] aqi_next;
    logic [CAT_W-1:0] cat_next;
    logic [AQI_W-1:0] aqi_reg;
    logic [CAT_W-1:0] cat_reg;
    logic             ok_reg;

    assign o_rdy    = !o_vld_reg || out_ready;
    assign in_ready = o_rdy;

    always_comb
    begin
        sum      = (AQI_W+1)'(in_quo.quo) + (AQI_W+1)'(BAND_IDX_LO[in_quo.band]);
        aqi_next = sum[AQI_W] ? {AQI_W{1'b1}} : sum[AQI_W-1:0];
        priority if (aqi_next >= AQI_W'(301))
            cat_next = CAT_HAZARDOUS;
        else if (aqi_next >= AQI_W'(201))
            cat_next = CAT_VERY_UNHLT;
        else if (aqi_next >= AQI_W'(151))
            cat_next = CAT_UNHEALTHY;
        else if (aqi_next >= AQI_W'(101))
            cat_next = CAT_SENSITIVE;
        else if (aqi_next >= AQI_W'(51))
            cat_next = CAT_MODERATE;
        else
            cat_next = CAT_GOOD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (o_rdy)
        begin
            o_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && o_rdy)
        begin
            aqi_reg <= in_quo.neg ? '0 : aqi_next;
            cat_reg <= in_quo.neg ? CAT_GOOD : cat_next;
            ok_reg  <= !in_quo.neg;
        end
    end

    assign out_valid     = o_vld_reg;
    assign aqi_value     = aqi_reg;
    assign category_code = cat_reg;
    assign result_valid  = ok_reg;

endmodule

// ----- sv/pm25_to_air_quality_index_top.sv -----
// Top level of the PM2.5 to air quality index converter.
// Depends on pm25aqi_pkg, pm25aqi_corr, pm25aqi_interp, pm25aqi_grade.
//
// Usage:
//   Input stream (s_axis): one transfer per sample, PM2.5 and relative
//   humidity both in tenths. Output stream (m_axis): one transfer per
//   sample, in order: rounded index and category code in tdata, and in
//   tuser a flag that is low when the humidity-corrected concentration
//   came out negative (index and category then read zero).
//   Pipeline: six register stages, one each for correction, band select,
//   numerator, reciprocal multiply, quotient correction and offset/category.
//   Throughput: one sample per cycle while m_axis is not stalled; the
//   reciprocal multiply and the back-multiply in the correction stage are
//   the deepest paths.
//   Division by twice the band width is a multiply by a per-band reciprocal,
//   then one compare and subtract that fixes the quotient up by one.
//   Stalls: each stage has its own valid bit and loads when the stage
//   after it is empty or moving, so a stalled m_axis fills bubbles first;
//   s_axis_tready drops only when all six stages hold a sample. Nothing
//   is dropped or repeated.
//   Reset: clears all valid bits; the data registers are not reset.
module pm25_to_air_quality_index_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [13:0] pm25_tenths, [23:14] humidity_tenths
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] aqi_value, [12:10] category_code, rest 0
    output logic [0:0]  m_axis_tuser    // [0] result_valid
);
    import pm25aqi_pkg::*;

    logic             corr_vld;
    logic             corr_rdy;
    band_t            corr_band;
    logic             intp_vld;
    logic             intp_rdy;
    quo_t             intp_quo;
    logic [AQI_W-1:0] aqi_value;
    logic [CAT_W-1:0] category_code;
    logic             result_valid;

    pm25aqi_corr u_corr (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .pm25_tenths     (s_axis_tdata[PM_W-1:0]),
        .humidity_tenths (s_axis_tdata[PM_W+RH_W-1:PM_W]),
        .out_valid       (corr_vld),
        .out_ready       (corr_rdy),
        .out_band        (corr_band)
    );

    pm25aqi_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (corr_vld),
        .in_ready  (corr_rdy),
        .in_band   (corr_band),
        .out_valid (intp_vld),
        .out_ready (intp_rdy),
        .out_quo   (intp_quo)
    );

    pm25aqi_grade u_grade (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (intp_vld),
        .in_ready      (intp_rdy),
        .in_quo        (intp_quo),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .aqi_value     (aqi_value),
        .category_code (category_code),
        .result_valid  (result_valid)
    );

    assign m_axis_tdata = {3'b000, category_code, aqi_value};
    assign m_axis_tuser = result_valid;

    // Invalid results carry all-zero payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0))
        else $error("invalid result with nonzero payload");

    // Category must agree with the index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0] && (aqi_value >= AQI_W'(301)))
            |-> (category_code == CAT_HAZARDOUS))
        else $error("category mismatch at hazardous index");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0] && (aqi_value <= AQI_W'(50)))
            |-> (category_code == CAT_GOOD))
        else $error("category mismatch at good index");

    // An empty output stage opens the whole pipeline to new input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage empty");

endmodule

// ----- sim/aqi_result_checker.sv -----
// Result checker for the PM2.5 to air quality index converter.
// Watches both stream channels, predicts each result and compares; needs pm25aqi_pkg.
module aqi_result_checker (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           s_tvalid,
    input  logic                                           s_tready,
    input  logic [pm25aqi_pkg::RH_W+pm25aqi_pkg::PM_W-1:0] s_tdata,
                                                 // [13:0] pm25_tenths, [23:14] humidity_tenths
    input  logic                                           m_tvalid,
    input  logic                                           m_tready,
    input  logic [15:0]                                    m_tdata,
                                                 // [9:0] aqi_value, [12:10] category_code
    input  logic [0:0]                                     m_tuser,    // [0] result_valid
    output int                                             fail_count,
    output int                                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pm25aqi_pkg::*;

    typedef struct packed {
        logic [AQI_W-1:0] aqi;
        logic [CAT_W-1:0] cat;
        logic             valid;
    } grade_t;

    grade_t expected_grades [$];
    int     fails  = 0;
    int     queued = 0;

    assign fail_count = fails;
    assign pending    = queued;

    // Exact humidity correction, band lookup and half-up rounded interpolation.
    function automatic grade_t expected_grade(input logic [PM_W-1:0] pm,
                                              input logic [RH_W-1:0] rh);
        longint pm_l;
        longint rh_l;
        longint conc;
        longint lo;
        longint hi;
        longint ilo;
        longint ihi;
        longint num;
        longint den;
        longint idx;
        grade_t g;
        pm_l = pm;
        rh_l = rh;
        conc = 5340 * pm_l - 844 * rh_l + 560400;
        g = '0;
        if (conc < 0)
        begin
            return g;
        end
        // strict greater-than on each lower breakpoint, top band first
        if (conc > 35050000)
        begin
            lo = 35050000; hi = 50040000; ilo = 401; ihi = 500;
        end
        else if (conc > 25050000)
        begin
            lo = 25050000; hi = 35040000; ilo = 301; ihi = 400;
        end
        else if (conc > 15050000)
        begin
            lo = 15050000; hi = 25040000; ilo = 201; ihi = 300;
        end
        else if (conc > 5550000)
        begin
            lo = 5550000; hi = 15040000; ilo = 151; ihi = 200;
        end
        else if (conc > 3550000)
        begin
            lo = 3550000; hi = 5540000; ilo = 101; ihi = 150;
        end
        else if (conc > 1210000)
        begin
            lo = 1210000; hi = 3540000; ilo = 51; ihi = 100;
        end
        else
        begin
            // good band, also covers the 12.0..12.1 gap by extrapolation
            lo = 0; hi = 1200000; ilo = 0; ihi = 50;
        end
        num = (ihi - ilo) * (conc - lo);
        den = hi - lo;
        idx = (2 * num + den) / (2 * den) + ilo;
        if (idx > 1023)
        begin
            idx = 1023;
        end
        g.aqi   = idx[AQI_W-1:0];
        g.valid = 1'b1;
        if (idx >= 301)      g.cat = CAT_HAZARDOUS;
        else if (idx >= 201) g.cat = CAT_VERY_UNHLT;
        else if (idx >= 151) g.cat = CAT_UNHEALTHY;
        else if (idx >= 101) g.cat = CAT_SENSITIVE;
        else if (idx >= 51)  g.cat = CAT_MODERATE;
        else                 g.cat = CAT_GOOD;
        return g;
    endfunction

    always @(posedge clk)
    begin
        grade_t want;
        if (rst_n)
        begin
            // result side first, so a result never matches a sample taken at the same edge
            if (m_tvalid && m_tready)
            begin
                if (expected_grades.size() == 0)
                begin
                    $error("unexpected result transfer: tdata %h tuser %b", m_tdata, m_tuser);
                    fails++;
                end
                else
                begin
                    want = expected_grades.pop_front();
                    if (m_tdata[AQI_W-1:0] !== want.aqi)
                    begin
                        $error("aqi_value: expected %0d, got %0d", want.aqi, m_tdata[AQI_W-1:0]);
                        fails++;
                    end
                    if (m_tdata[AQI_W+CAT_W-1:AQI_W] !== want.cat)
                    begin
                        $error("category_code: expected %0d, got %0d", want.cat,
                               m_tdata[AQI_W+CAT_W-1:AQI_W]);
                        fails++;
                    end
                    if (m_tdata[15:AQI_W+CAT_W] !== '0)
                    begin
                        $error("tdata padding: expected 0, got %0h", m_tdata[15:AQI_W+CAT_W]);
                        fails++;
                    end
                    if (m_tuser[0] !== want.valid)
                    begin
                        $error("result_valid: expected %0d, got %0d", want.valid, m_tuser[0]);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_grades.push_back(expected_grade(s_tdata[PM_W-1:0],
                                                         s_tdata[RH_W+PM_W-1:PM_W]));
            end
            queued = expected_grades.size();
        end
    end

endmodule

// ----- sim/tb_pm25_to_air_quality_index_top.sv -----
// Testbench top for the PM2.5 to air quality index converter.
// Drives samples with random gaps and output stalls; needs pm25aqi_pkg and aqi_result_checker.
module tb_pm25_to_air_quality_index_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pm25aqi_pkg::*;

    localparam int RANDOM_SAMPLES = 550;
    localparam int DRAIN_CYCLES   = 20;     // well past the pipeline depth

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [RH_W+PM_W-1:0] s_data  = '0;     // [13:0] pm25_tenths, [23:14] humidity_tenths
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [15:0]          m_data;           // [9:0] aqi_value, [12:10] category_code
    logic [0:0]           m_user;           // [0] result_valid
    int                   fail_count;
    int                   pending;

    int src_burst = 0;      // transfers left in a back-to-back stretch
    int rdy_hold  = 0;      // cycles left before tready changes

    always #5 clk = ~clk;

    pm25_to_air_quality_index_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    aqi_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_valid),
        .s_tready   (s_ready),
        .s_tdata    (s_data),
        .m_tvalid   (m_valid),
        .m_tready   (m_ready),
        .m_tdata    (m_data),
        .m_tuser    (m_user),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Idle length in cycles: usually from the short range, now and then from the long one.
    function automatic int idle_len();
        if ($urandom_range(99) < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Output backpressure: alternating ready/stall runs, with occasional
    // long runs of ready so the pipeline also streams at full rate.
    always @(posedge clk)
    begin
        if (rdy_hold > 0)
        begin
            rdy_hold <= rdy_hold - 1;
        end
        else if (m_ready)
        begin
            m_ready  <= 1'b0;
            rdy_hold <= idle_len() - 1;
        end
        else
        begin
            m_ready  <= 1'b1;
            rdy_hold <= ($urandom_range(11) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 7);
        end
    end

    // One input transfer. tvalid is only lowered when a gap is taken, so a
    // back-to-back transfer never sees tvalid dropped and raised in one step.
    task automatic send_sample(input logic [PM_W-1:0] pm, input logic [RH_W-1:0] rh);
        int gap;
        if (src_burst > 0)
        begin
            src_burst--;
            gap = 0;
        end
        else if ($urandom_range(14) == 0)
        begin
            src_burst = $urandom_range(30, 80);
            gap = 0;
        end
        else if ($urandom_range(1) == 0)
        begin
            gap = 0;
        end
        else
        begin
            gap = idle_len();
        end
        if (gap > 0)
        begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {rh, pm};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
    endtask

    // Find a sample whose corrected concentration lands on or next to the
    // target (concentrations step by 4 in 1e-5 ug/m3), searching outward.
    task automatic find_sample(input longint target, output logic [PM_W-1:0] pm,
                               output logic [RH_W-1:0] rh);
        longint t;
        longint v;
        int     k;
        int     r;
        bit     found;
        found = 1'b0;
        pm = '0;
        rh = '0;
        for (k = 0; k < 4000 && !found; k++)
        begin
            t = target + 4 * ((k + 1) / 2) * ((k % 2) ? -1 : 1);
            for (r = 0; r < 1024 && !found; r++)
            begin
                v = t - 560400 + 844 * r;
                if (v >= 0 && v % 5340 == 0 && v / 5340 < 16384)
                begin
                    found = 1'b1;
                    pm = PM_W'(v / 5340);
                    rh = RH_W'(r);
                end
            end
        end
    endtask

    task automatic send_near(input longint target);
        logic [PM_W-1:0] pm;
        logic [RH_W-1:0] rh;
        find_sample(target, pm, rh);
        send_sample(pm, rh);
    endtask

    // Random sample: mostly in range, weighted toward the low bands, some
    // full-width values, and some right around a band breakpoint.
    task automatic random_sample(output logic [PM_W-1:0] pm, output logic [RH_W-1:0] rh);
        int     k;
        longint base;
        k = $urandom_range(99);
        if (k < 35)
        begin
            pm = PM_W'($urandom_range(800));
        end
        else if (k < 72)
        begin
            pm = PM_W'($urandom_range(10000));
        end
        else if (k < 87)
        begin
            pm = PM_W'($urandom_range(16383));
        end
        if ($urandom_range(99) < 85)
        begin
            rh = RH_W'($urandom_range(1000));
        end
        else
        begin
            rh = RH_W'($urandom_range(1023));
        end
        if (k >= 87)
        begin
            case ($urandom_range(8))
                0: base = 0;
                1: base = 1200000;
                2: base = 1210000;
                3: base = 3550000;
                4: base = 5550000;
                5: base = 15050000;
                6: base = 25050000;
                7: base = 35050000;
                default: base = 50040000;
            endcase
            find_sample(base + 4 * $signed($urandom_range(400)) - 800, pm, rh);
        end
    endtask

    initial
    begin
        logic [PM_W-1:0] pm;
        logic [RH_W-1:0] rh;
        int              n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes
        send_sample(PM_W'(0), RH_W'(0));
        send_sample(PM_W'(16383), RH_W'(1023));     // beyond range, top band extrapolated
        send_sample(PM_W'(10000), RH_W'(0));
        send_sample(PM_W'(0), RH_W'(1000));         // negative corrected value
        send_sample(PM_W'(0), RH_W'(1023));
        // just below and at zero concentration
        send_near(-4);
        send_near(0);
        // good band top, the 12.0..12.1 gap, and each breakpoint on and just past
        send_near(1200000);
        send_near(1204000);
        send_near(1210000);
        send_near(1210004);
        send_near(3550000);
        send_near(3550004);
        send_near(5550000);
        send_near(5550004);
        send_near(15050000);
        send_near(15050004);
        send_near(25050000);
        send_near(25050004);
        send_near(35050000);
        send_near(35050004);
        // top band past 500.4
        send_near(50040000);
        send_near(50040004);

        for (n = 0; n < RANDOM_SAMPLES; n++)
        begin
            random_sample(pm, rh);
            send_sample(pm, rh);
        end
        s_valid <= 1'b0;

        // let the checker record the last input transfer before polling its count
        @(posedge clk);
        // drain, then give any stray result time to show up
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
